// File: hw/rtl/ssfl_pkg.sv
`default_nettype none

package ssfl_pkg;

    localparam int BYTE_BITS      = 8;
    localparam int CFG_DATA_BITS  = 64;
    localparam int CFG_INDEX_BITS = 2;
    localparam int LEN_REG_BITS   = 5;
    localparam int MODE_REG_BITS  = 3;
    localparam int OUT_BITS       = 32;
    localparam int PAT_CFG_BYTES  = 16;

    localparam logic [CFG_INDEX_BITS-1:0] CFG_PATTERN_LOW  = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_PATTERN_HIGH = 2'd1;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_PATTERN_LEN  = 2'd2;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_SEARCH_MODE  = 2'd3;

    localparam logic [1:0] KIND_FOUND_ONLY = 2'd0;
    localparam logic [1:0] KIND_START      = 2'd1;
    localparam logic [1:0] KIND_AFTER      = 2'd2;

    localparam logic [LEN_REG_BITS-1:0]  LEN_RESET  = 5'd1;
    localparam logic [MODE_REG_BITS-1:0] MODE_RESET = 3'd2;

    typedef struct packed {
        logic shift;
        logic clear;
    } t_cell_ctl;

endpackage

`default_nettype wire

// File: hw/rtl/ssfl_cell.sv
`default_nettype none

module ssfl_cell (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire ssfl_pkg::t_cell_ctl             i_ctl,
    input  wire logic [ssfl_pkg::BYTE_BITS-1:0]  i_byte,
    input  wire logic [ssfl_pkg::BYTE_BITS-1:0]  i_pattern,
    output logic      [ssfl_pkg::BYTE_BITS-1:0]  o_byte,
    output logic                                 o_equal
);

    logic [ssfl_pkg::BYTE_BITS-1:0] r_byte;
    logic [ssfl_pkg::BYTE_BITS-1:0] n_byte;

    always_comb begin
        n_byte = r_byte;
        if (i_ctl.clear) begin
            n_byte = '0;
        end else if (i_ctl.shift) begin
            n_byte = i_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byte <= '0;
        end else begin
            r_byte <= n_byte;
        end
    end

    assign o_byte  = r_byte;
    assign o_equal = (i_byte == i_pattern);

endmodule

`default_nettype wire

// File: hw/rtl/substring_search_first_last.sv
`default_nettype none

// Streaming exact substring search, first or last occurrence.
// Input channel (i_in_valid / o_in_stall) carries one haystack transaction
// per cycle: a byte (i_byte_valid), an end marker (i_end_of_haystack) or both.
// A row of PATTERN_MAX window cells shifts each byte in and compares the
// newest pattern_length bytes with the pattern in the same cycle, so the
// block takes one transaction every cycle while o_in_stall is low.
// The end transaction produces one result on the output channel
// (o_out_valid / i_out_stall) in the cycle after it is accepted; the byte
// it carries is counted first. Accepting the end also clears the window,
// byte count and match state for the next haystack.
// While a result waits and i_out_stall is high, o_in_stall is raised and the
// result holds; otherwise input keeps flowing while the result is taken.
// Configuration writes (i_cfg_we, i_cfg_index, i_cfg_data) take effect at the
// next clock edge. Synchronous reset clears the window and match state and
// loads pattern length 1 and mode "match start index, first occurrence".

module substring_search_first_last #(
    parameter int PATTERN_MAX   = 16,
    parameter int POSITION_BITS = 32
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_in_valid,
    output logic                                     o_in_stall,
    input  wire logic [ssfl_pkg::BYTE_BITS-1:0]      i_data_byte,
    input  wire logic                                i_byte_valid,
    input  wire logic                                i_end_of_haystack,
    output logic                                     o_out_valid,
    input  wire logic                                i_out_stall,
    output logic                                     o_match_found,
    output logic      [ssfl_pkg::OUT_BITS-1:0]       o_match_position,
    output logic                                     o_position_overflow,
    input  wire logic                                i_cfg_we,
    input  wire logic [ssfl_pkg::CFG_INDEX_BITS-1:0] i_cfg_index,
    input  wire logic [ssfl_pkg::CFG_DATA_BITS-1:0]  i_cfg_data
);

    localparam int BB  = ssfl_pkg::BYTE_BITS;
    localparam int LW  = $clog2(PATTERN_MAX + 1);
    localparam int LCW = (LW > ssfl_pkg::LEN_REG_BITS) ? LW : ssfl_pkg::LEN_REG_BITS;
    localparam int EW  = (POSITION_BITS > ssfl_pkg::OUT_BITS) ? POSITION_BITS
                                                               : ssfl_pkg::OUT_BITS;

    logic [ssfl_pkg::CFG_DATA_BITS-1:0]  r_pat_low;
    logic [ssfl_pkg::CFG_DATA_BITS-1:0]  r_pat_high;
    logic [ssfl_pkg::LEN_REG_BITS-1:0]   r_len;
    logic [ssfl_pkg::MODE_REG_BITS-1:0]  r_mode;

    logic [POSITION_BITS-1:0] r_seen;
    logic [POSITION_BITS-1:0] n_seen;
    logic                     r_have;
    logic                     n_have;
    logic [POSITION_BITS-1:0] r_start;
    logic [POSITION_BITS-1:0] n_start;
    logic                     r_ovf;
    logic                     n_ovf;

    logic                          r_out_valid;
    logic                          r_found;
    logic [ssfl_pkg::OUT_BITS-1:0] r_pos;
    logic                          r_pos_ovf;

    logic                      w_in_acc;
    logic                      w_byte_acc;
    logic                      w_end_acc;
    logic [2*ssfl_pkg::CFG_DATA_BITS-1:0] w_pat_cfg;
    logic [PATTERN_MAX*BB-1:0] w_pat;
    logic [PATTERN_MAX*BB-1:0] w_rev;
    logic [PATTERN_MAX*BB-1:0] w_aligned;
    logic [LCW-1:0]            w_len_raw;
    logic [LW-1:0]             w_len;
    logic [LW-1:0]             w_shift;
    logic [PATTERN_MAX-1:0]    w_equal;
    logic [PATTERN_MAX-1:0]    w_mask;
    logic [PATTERN_MAX*BB-1:0] w_chain_in;
    logic [PATTERN_MAX*BB-1:0] w_cell_byte;
    ssfl_pkg::t_cell_ctl       w_ctl;

    logic                     w_seen_full;
    logic                     w_ovf_byte;
    logic [POSITION_BITS-1:0] w_seen_inc;
    logic [POSITION_BITS-1:0] w_len_pos;
    logic                     w_enough;
    logic                     w_hit;
    logic                     w_take;
    logic [POSITION_BITS-1:0] w_start_new;
    logic [POSITION_BITS-1:0] w_end_new;
    logic                     w_have_post;
    logic [POSITION_BITS-1:0] w_start_post;
    logic                     w_ovf_post;
    logic [POSITION_BITS:0]   w_after_sum;
    logic [POSITION_BITS-1:0] w_after_kept;
    logic [POSITION_BITS-1:0] w_after;
    logic [POSITION_BITS-1:0] w_pos;
    logic [EW-1:0]            w_pos_ext;
    logic                     w_pos_big;

    assign o_in_stall = r_out_valid & i_out_stall;
    assign w_in_acc   = i_in_valid & ~o_in_stall;
    assign w_byte_acc = w_in_acc & i_byte_valid;
    assign w_end_acc  = w_in_acc & i_end_of_haystack;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pat_low  <= '0;
            r_pat_high <= '0;
            r_len      <= ssfl_pkg::LEN_RESET;
            r_mode     <= ssfl_pkg::MODE_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                ssfl_pkg::CFG_PATTERN_LOW:  r_pat_low  <= i_cfg_data;
                ssfl_pkg::CFG_PATTERN_HIGH: r_pat_high <= i_cfg_data;
                ssfl_pkg::CFG_PATTERN_LEN:  r_len <= i_cfg_data[ssfl_pkg::LEN_REG_BITS-1:0];
                ssfl_pkg::CFG_SEARCH_MODE:  r_mode <= i_cfg_data[ssfl_pkg::MODE_REG_BITS-1:0];
                default: ;
            endcase
        end
    end

    assign w_len_raw = LCW'(r_len);

    always_comb begin
        if (w_len_raw == '0) begin
            w_len = LW'(1);
        end else if (w_len_raw > LCW'(PATTERN_MAX)) begin
            w_len = LW'(PATTERN_MAX);
        end else begin
            w_len = w_len_raw[LW-1:0];
        end
    end

    assign w_pat_cfg = {r_pat_high, r_pat_low};
    assign w_shift   = LW'(PATTERN_MAX) - w_len;
    assign w_aligned = w_rev >> {w_shift, 3'b000};

    assign w_ctl.shift = w_byte_acc;
    assign w_ctl.clear = w_end_acc;

    assign w_chain_in[BB-1:0] = i_data_byte;

    genvar g;
    generate
        for (g = 0; g < PATTERN_MAX; g++) begin : g_cell
            if (g < ssfl_pkg::PAT_CFG_BYTES) begin : g_cfg
                assign w_pat[g*BB +: BB] = w_pat_cfg[g*BB +: BB];
            end else begin : g_zero
                assign w_pat[g*BB +: BB] = '0;
            end
            assign w_rev[g*BB +: BB] = w_pat[(PATTERN_MAX-1-g)*BB +: BB];
            assign w_mask[g] = (LW'(g) < w_len);
            if (g > 0) begin : g_link
                assign w_chain_in[g*BB +: BB] = w_cell_byte[(g-1)*BB +: BB];
            end

            ssfl_cell u_cell (
                .i_clk     (i_clk),
                .i_rst_n   (i_rst_n),
                .i_ctl     (w_ctl),
                .i_byte    (w_chain_in[g*BB +: BB]),
                .i_pattern (w_aligned[g*BB +: BB]),
                .o_byte    (w_cell_byte[g*BB +: BB]),
                .o_equal   (w_equal[g])
            );
        end
    endgenerate

    assign w_seen_full = (r_seen == '1);
    assign w_ovf_byte  = r_ovf | w_seen_full;
    assign w_seen_inc  = w_seen_full ? r_seen : r_seen + POSITION_BITS'(1);
    assign w_len_pos   = POSITION_BITS'(w_len);
    assign w_enough    = w_ovf_byte | (w_seen_inc >= w_len_pos);
    assign w_hit       = i_byte_valid & w_enough & (&(w_equal | ~w_mask));
    assign w_take      = w_hit & (~r_have | r_mode[0]);
    assign w_start_new = w_ovf_byte ? '1 : w_seen_inc - w_len_pos;
    assign w_end_new   = w_ovf_byte ? '1 : w_seen_inc;

    assign w_have_post  = r_have | w_take;
    assign w_start_post = w_take ? w_start_new : r_start;
    assign w_ovf_post   = i_byte_valid ? w_ovf_byte : r_ovf;

    assign w_after_sum  = {1'b0, r_start} + (POSITION_BITS+1)'(w_len);
    assign w_after_kept = w_after_sum[POSITION_BITS] ? '1 : w_after_sum[POSITION_BITS-1:0];
    assign w_after      = w_take ? w_end_new : w_after_kept;

    always_comb begin
        w_pos = '0;
        if (w_have_post) begin
            case (r_mode[2:1])
                ssfl_pkg::KIND_START: w_pos = w_start_post;
                ssfl_pkg::KIND_AFTER: w_pos = w_after;
                default:              w_pos = '0;
            endcase
        end
    end

    assign w_pos_ext = EW'(w_pos);
    assign w_pos_big = |(w_pos_ext >> ssfl_pkg::OUT_BITS);

    always_comb begin
        n_seen  = r_seen;
        n_have  = r_have;
        n_start = r_start;
        n_ovf   = r_ovf;
        if (w_end_acc) begin
            n_seen  = '0;
            n_have  = 1'b0;
            n_start = '0;
            n_ovf   = 1'b0;
        end else if (w_byte_acc) begin
            n_seen  = w_seen_inc;
            n_have  = w_have_post;
            n_start = w_start_post;
            n_ovf   = w_ovf_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen      <= '0;
            r_have      <= 1'b0;
            r_start     <= '0;
            r_ovf       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_seen  <= n_seen;
            r_have  <= n_have;
            r_start <= n_start;
            r_ovf   <= n_ovf;
            if (w_end_acc) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_end_acc) begin
            r_found   <= w_have_post;
            r_pos     <= w_pos_big ? '1 : w_pos_ext[ssfl_pkg::OUT_BITS-1:0];
            r_pos_ovf <= w_ovf_post | w_pos_big;
        end
    end

    assign o_out_valid         = r_out_valid;
    assign o_match_found       = r_found;
    assign o_match_position    = r_pos;
    assign o_position_overflow = r_pos_ovf;

endmodule

`default_nettype wire
